>>> rtl/core/r2ntt_pkg.sv
// r2ntt_pkg: shared types, codes and modular helpers of the radix-2 ntt engine
// depends on nothing; used by every file under rtl/core
`default_nettype none

package r2ntt_pkg;

    localparam int RES_W     = 60;
    localparam int IDX_W     = 10;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int LOG_W     = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS    = 2'd0,
        CFG_ROOT       = 2'd1,
        CFG_LOG_SIZE   = 2'd2,
        CFG_NEGACYCLIC = 2'd3
    } t_cfg_idx;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_XFORM = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_kind;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [IDX_W-1:0] index;
        logic [RES_W-1:0] coeff_value;
    } t_in;

    typedef struct packed {
        logic [RES_W-1:0] read_value;
        logic             index_error;
        logic             transform_done;
    } t_out;

    typedef enum logic [2:0] {
        RESP_NONE = 3'd0,
        RESP_ZERO = 3'd1,
        RESP_ERR  = 3'd2,
        RESP_READ = 3'd3,
        RESP_DONE = 3'd4
    } t_resp;

    typedef enum logic [2:0] {
        WS_RED = 3'd0,
        WS_X   = 3'd1,
        WS_Y   = 3'd2,
        WS_SUM = 3'd3,
        WS_DIF = 3'd4
    } t_wsel;

    typedef enum logic [1:0] {
        MS_WY = 2'd0,
        MS_AA = 2'd1,
        MS_WS = 2'd2
    } t_msel;

    typedef enum logic [1:0] {
        RS_COEF  = 2'd0,
        RS_ROOT  = 2'd1,
        RS_RDATA = 2'd2
    } t_rsel;

    typedef enum logic [1:0] {
        WL_NONE = 2'd0,
        WL_ONE  = 2'd1,
        WL_A    = 2'd2,
        WL_MUL  = 2'd3
    } t_wld;

    typedef enum logic [1:0] {
        SL_NONE = 2'd0,
        SL_A    = 2'd1,
        SL_MUL  = 2'd2
    } t_sld;

    typedef struct packed {
        logic  latch;
        logic  rd_en;
        logic  wr_en;
        t_wsel wsel;
        logic  red_go;
        t_rsel rsel;
        logic  mul_go;
        t_msel msel;
        logic  ld_w0;
        logic  ld_a_w0;
        logic  ld_a_mul;
        t_wld  wld;
        t_sld  sld;
        logic  ld_x;
        logic  ld_y;
        t_resp resp;
    } t_cmd;

    typedef struct packed {
        t_req_kind        kind;
        logic [IDX_W-1:0] index;
        logic             idx_err;
        logic             red_done;
        logic             mul_done;
    } t_stat;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LD_WAIT,
        ST_RD_OUT,
        ST_ROOT_WAIT,
        ST_RED_RD,
        ST_RED_GO,
        ST_RED_WAIT,
        ST_BR_CHK,
        ST_BR_RD1,
        ST_BR_RD2,
        ST_BR_CAP,
        ST_BR_WR1,
        ST_BR_WR2,
        ST_INIT,
        ST_SQ,
        ST_SQ_WAIT,
        ST_TW_INIT,
        ST_TW_SQW,
        ST_BF_RD1,
        ST_BF_RD2,
        ST_BF_MUL,
        ST_BF_WAIT,
        ST_BF_WR1,
        ST_BF_WR2,
        ST_TW_STEP,
        ST_TW_SW,
        ST_DONE
    } t_state;

    // operands below p
    function automatic logic [RES_W-1:0] add_mod(input logic [RES_W-1:0] a,
                                                 input logic [RES_W-1:0] b,
                                                 input logic [RES_W-1:0] p);
        logic [RES_W-1:0] d;
        d = p - b;
        if (a >= d) begin
            return a - d;
        end
        return a + b;
    endfunction

    function automatic logic [RES_W-1:0] sub_mod(input logic [RES_W-1:0] a,
                                                 input logic [RES_W-1:0] b,
                                                 input logic [RES_W-1:0] p);
        if (a >= b) begin
            return a - b;
        end
        return a + (p - b);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/r2ntt_modred.sv
// r2ntt_modred: restoring remainder unit, one dividend bit per cycle
// depends on r2ntt_pkg
`default_nettype none

module r2ntt_modred (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_go,
    input  wire [r2ntt_pkg::RES_W-1:0]   i_x,
    input  wire [r2ntt_pkg::RES_W-1:0]   i_p,
    output logic                         o_done,
    output logic [r2ntt_pkg::RES_W-1:0]  o_q
);

    localparam int W  = r2ntt_pkg::RES_W;
    localparam int CW = $clog2(W);

    logic [W-1:0]  r_x;
    logic [W-1:0]  r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    trial;

    // shift in the next dividend bit, subtract p once if it fits
    always_comb begin
        trial = {r_rem, r_x[W-1]};
        if (trial >= {1'b0, i_p}) begin
            trial = trial - {1'b0, i_p};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_x   <= i_x;
            r_rem <= '0;
        end else if (r_busy) begin
            r_x   <= {r_x[W-2:0], 1'b0};
            r_rem <= trial[W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_q    = r_rem;

endmodule

`default_nettype wire

>>> rtl/core/r2ntt_mulmod.sv
// r2ntt_mulmod: shift-and-add modular multiplier, one multiplier bit per cycle
// depends on r2ntt_pkg (add_mod)
`default_nettype none

module r2ntt_mulmod (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_go,
    input  wire [r2ntt_pkg::RES_W-1:0]   i_a,
    input  wire [r2ntt_pkg::RES_W-1:0]   i_b,
    input  wire [r2ntt_pkg::RES_W-1:0]   i_p,
    output logic                         o_done,
    output logic [r2ntt_pkg::RES_W-1:0]  o_q
);

    localparam int W = r2ntt_pkg::RES_W;

    logic [W-1:0] r_acc;
    logic [W-1:0] r_a;
    logic [W-1:0] r_b;
    logic         r_busy;
    logic         r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_b == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // both adds work on independent operands, so they run in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r2ntt_pkg::add_mod(r_acc, r_a, i_p);
            end
            r_a <= r2ntt_pkg::add_mod(r_a, r_a, i_p);
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_q    = r_acc;

endmodule

`default_nettype wire

>>> rtl/core/r2ntt_dp.sv
// r2ntt_dp: coefficient memory, twiddle registers, arithmetic units and result register
// depends on r2ntt_pkg, r2ntt_modred, r2ntt_mulmod
`default_nettype none

module r2ntt_dp #(
    parameter int MAX_SIZE  = 1024,
    parameter int WORD_BITS = 60,
    parameter int AW        = 10,
    parameter int LW        = 4
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  r2ntt_pkg::t_in               i_req,
    input  wire [r2ntt_pkg::RES_W-1:0]   i_p,
    input  wire [r2ntt_pkg::RES_W-1:0]   i_root,
    input  wire [LW-1:0]                 i_lg,
    input  r2ntt_pkg::t_cmd              i_cmd,
    input  wire [AW-1:0]                 i_rd_addr,
    input  wire [AW-1:0]                 i_wr_addr,
    output r2ntt_pkg::t_stat             o_stat,
    output logic                         o_valid,
    output r2ntt_pkg::t_out              o_res
);

    localparam int W = r2ntt_pkg::RES_W;

    logic [WORD_BITS-1:0] mem [MAX_SIZE];
    logic [WORD_BITS-1:0] r_rdata;

    r2ntt_pkg::t_in  r_req;
    r2ntt_pkg::t_out r_res;
    r2ntt_pkg::t_out n_res;
    logic            r_valid;

    logic [W-1:0] r_w0;
    logic [W-1:0] r_a;
    logic [W-1:0] r_w;
    logic [W-1:0] r_step;
    logic [W-1:0] r_x;
    logic [W-1:0] r_y;

    logic [W-1:0] rdata_res;
    logic [W-1:0] red_op;
    logic [W-1:0] mul_a;
    logic [W-1:0] mul_b;
    logic [W-1:0] red_q;
    logic [W-1:0] mul_q;
    logic [W-1:0] wdata;
    logic         red_done;
    logic         mul_done;

    assign rdata_res = W'(r_rdata);

    always_comb begin
        case (i_cmd.rsel)
            r2ntt_pkg::RS_COEF:  red_op = r_req.coeff_value;
            r2ntt_pkg::RS_ROOT:  red_op = i_root;
            r2ntt_pkg::RS_RDATA: red_op = rdata_res;
            default:             red_op = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.msel)
            r2ntt_pkg::MS_WY: begin
                mul_a = r_w;
                mul_b = r_y;
            end
            r2ntt_pkg::MS_AA: begin
                mul_a = r_a;
                mul_b = r_a;
            end
            r2ntt_pkg::MS_WS: begin
                mul_a = r_w;
                mul_b = r_step;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    r2ntt_modred u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.red_go),
        .i_x     (red_op),
        .i_p     (i_p),
        .o_done  (red_done),
        .o_q     (red_q)
    );

    r2ntt_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_p     (i_p),
        .o_done  (mul_done),
        .o_q     (mul_q)
    );

    // butterfly: u in x, t in the multiplier result
    always_comb begin
        case (i_cmd.wsel)
            r2ntt_pkg::WS_RED: wdata = red_q;
            r2ntt_pkg::WS_X:   wdata = r_x;
            r2ntt_pkg::WS_Y:   wdata = r_y;
            r2ntt_pkg::WS_SUM: wdata = r2ntt_pkg::add_mod(r_x, mul_q, i_p);
            r2ntt_pkg::WS_DIF: wdata = r2ntt_pkg::sub_mod(r_x, mul_q, i_p);
            default:           wdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_wr_addr] <= WORD_BITS'(wdata);
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req;
        end
        if (i_cmd.ld_w0) begin
            r_w0 <= red_q;
        end
        if (i_cmd.ld_a_w0) begin
            r_a <= r_w0;
        end else if (i_cmd.ld_a_mul) begin
            r_a <= mul_q;
        end
        case (i_cmd.wld)
            r2ntt_pkg::WL_ONE:  r_w <= W'(1);
            r2ntt_pkg::WL_A:    r_w <= r_a;
            r2ntt_pkg::WL_MUL:  r_w <= mul_q;
            default:            r_w <= r_w;
        endcase
        case (i_cmd.sld)
            r2ntt_pkg::SL_A:    r_step <= r_a;
            r2ntt_pkg::SL_MUL:  r_step <= mul_q;
            default:            r_step <= r_step;
        endcase
        if (i_cmd.ld_x) begin
            r_x <= rdata_res;
        end
        if (i_cmd.ld_y) begin
            r_y <= rdata_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.resp != r2ntt_pkg::RESP_NONE);
        end
    end

    always_comb begin
        n_res = '0;
        case (i_cmd.resp)
            r2ntt_pkg::RESP_READ: n_res.read_value     = rdata_res;
            r2ntt_pkg::RESP_ERR:  n_res.index_error    = 1'b1;
            r2ntt_pkg::RESP_DONE: n_res.transform_done = 1'b1;
            default:              n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_comb begin
        o_stat          = '0;
        o_stat.kind     = r2ntt_pkg::t_req_kind'(r_req.req_type);
        o_stat.index    = r_req.index;
        o_stat.idx_err  = ((r_req.index >> i_lg) != '0);
        o_stat.red_done = red_done;
        o_stat.mul_done = mul_done;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

>>> rtl/core/r2ntt_ctrl.sv
// r2ntt_ctrl: request sequencer and transform loop counters
// depends on r2ntt_pkg
`default_nettype none

module r2ntt_ctrl #(
    parameter int AW = 10,
    parameter int LW = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire [LW-1:0]         i_lg,
    input  wire                  i_nega,
    input  r2ntt_pkg::t_stat     i_stat,
    output logic                 o_busy,
    output r2ntt_pkg::t_cmd      o_cmd,
    output logic [AW-1:0]        o_rd_addr,
    output logic [AW-1:0]        o_wr_addr
);

    localparam int CW = AW + 1;
    localparam int SW = LW + 1;

    r2ntt_pkg::t_state r_state, n_state;
    r2ntt_pkg::t_cmd   cmd;

    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_j, n_j;
    logic [SW-1:0] r_s, n_s;
    logic [LW-1:0] r_c, n_c;

    logic [CW-1:0] len;
    logic [CW-1:0] half;
    logic [CW-1:0] span;
    logic [CW-1:0] k_h;
    logic [CW-1:0] k_next;
    logic [AW-1:0] rev_full;
    logic [AW-1:0] rev;
    logic [AW-1:0] idx_addr;
    logic          last_i;
    logic          last_j;
    logic          swap_need;
    logic          stage_over;

    assign len        = CW'(1) << i_lg;
    assign half       = CW'(1) << (r_s - SW'(1));
    assign span       = CW'(1) << r_s;
    assign k_h        = r_k + half;
    assign k_next     = r_k + span;
    assign last_i     = (r_i == len - CW'(1));
    assign last_j     = (r_j == half - CW'(1));
    assign stage_over = (r_s > SW'(i_lg));
    assign idx_addr   = AW'(i_stat.index);

    always_comb begin
        for (int b = 0; b < AW; b++) begin
            rev_full[b] = r_i[AW-1-b];
        end
    end

    assign rev       = rev_full >> (LW'(AW) - i_lg);
    assign swap_need = (rev > r_i[AW-1:0]);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            r2ntt_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = r2ntt_pkg::ST_DISPATCH;
                end
            end
            r2ntt_pkg::ST_DISPATCH: begin
                case (i_stat.kind)
                    r2ntt_pkg::REQ_LOAD: begin
                        n_state = i_stat.idx_err ? r2ntt_pkg::ST_IDLE
                                                 : r2ntt_pkg::ST_LD_WAIT;
                    end
                    r2ntt_pkg::REQ_READ: begin
                        n_state = i_stat.idx_err ? r2ntt_pkg::ST_IDLE
                                                 : r2ntt_pkg::ST_RD_OUT;
                    end
                    r2ntt_pkg::REQ_XFORM: n_state = r2ntt_pkg::ST_ROOT_WAIT;
                    default:              n_state = r2ntt_pkg::ST_IDLE;
                endcase
            end
            r2ntt_pkg::ST_LD_WAIT: begin
                if (i_stat.red_done) begin
                    n_state = r2ntt_pkg::ST_IDLE;
                end
            end
            r2ntt_pkg::ST_RD_OUT: n_state = r2ntt_pkg::ST_IDLE;
            r2ntt_pkg::ST_ROOT_WAIT: begin
                if (i_stat.red_done) begin
                    n_state = r2ntt_pkg::ST_RED_RD;
                end
            end
            r2ntt_pkg::ST_RED_RD: n_state = r2ntt_pkg::ST_RED_GO;
            r2ntt_pkg::ST_RED_GO: n_state = r2ntt_pkg::ST_RED_WAIT;
            r2ntt_pkg::ST_RED_WAIT: begin
                if (i_stat.red_done) begin
                    n_state = last_i ? r2ntt_pkg::ST_BR_CHK : r2ntt_pkg::ST_RED_RD;
                end
            end
            r2ntt_pkg::ST_BR_CHK: begin
                if (swap_need) begin
                    n_state = r2ntt_pkg::ST_BR_RD1;
                end else if (last_i) begin
                    n_state = r2ntt_pkg::ST_INIT;
                end
            end
            r2ntt_pkg::ST_BR_RD1: n_state = r2ntt_pkg::ST_BR_RD2;
            r2ntt_pkg::ST_BR_RD2: n_state = r2ntt_pkg::ST_BR_CAP;
            r2ntt_pkg::ST_BR_CAP: n_state = r2ntt_pkg::ST_BR_WR1;
            r2ntt_pkg::ST_BR_WR1: n_state = r2ntt_pkg::ST_BR_WR2;
            r2ntt_pkg::ST_BR_WR2: begin
                n_state = last_i ? r2ntt_pkg::ST_INIT : r2ntt_pkg::ST_BR_CHK;
            end
            r2ntt_pkg::ST_INIT: begin
                n_state = stage_over ? r2ntt_pkg::ST_DONE : r2ntt_pkg::ST_SQ;
            end
            r2ntt_pkg::ST_SQ: begin
                n_state = (r_c == '0) ? r2ntt_pkg::ST_TW_INIT : r2ntt_pkg::ST_SQ_WAIT;
            end
            r2ntt_pkg::ST_SQ_WAIT: begin
                if (i_stat.mul_done) begin
                    n_state = r2ntt_pkg::ST_SQ;
                end
            end
            r2ntt_pkg::ST_TW_INIT: begin
                n_state = i_nega ? r2ntt_pkg::ST_TW_SQW : r2ntt_pkg::ST_BF_RD1;
            end
            r2ntt_pkg::ST_TW_SQW: begin
                if (i_stat.mul_done) begin
                    n_state = r2ntt_pkg::ST_BF_RD1;
                end
            end
            r2ntt_pkg::ST_BF_RD1: n_state = r2ntt_pkg::ST_BF_RD2;
            r2ntt_pkg::ST_BF_RD2: n_state = r2ntt_pkg::ST_BF_MUL;
            r2ntt_pkg::ST_BF_MUL: n_state = r2ntt_pkg::ST_BF_WAIT;
            r2ntt_pkg::ST_BF_WAIT: begin
                if (i_stat.mul_done) begin
                    n_state = r2ntt_pkg::ST_BF_WR1;
                end
            end
            r2ntt_pkg::ST_BF_WR1: n_state = r2ntt_pkg::ST_BF_WR2;
            r2ntt_pkg::ST_BF_WR2: begin
                n_state = (k_next < len) ? r2ntt_pkg::ST_BF_RD1 : r2ntt_pkg::ST_TW_STEP;
            end
            r2ntt_pkg::ST_TW_STEP: begin
                n_state = last_j ? r2ntt_pkg::ST_INIT : r2ntt_pkg::ST_TW_SW;
            end
            r2ntt_pkg::ST_TW_SW: begin
                if (i_stat.mul_done) begin
                    n_state = r2ntt_pkg::ST_BF_RD1;
                end
            end
            r2ntt_pkg::ST_DONE: n_state = r2ntt_pkg::ST_IDLE;
            default:            n_state = r2ntt_pkg::ST_IDLE;
        endcase
    end

    // commands and counter updates
    always_comb begin
        cmd       = '0;
        o_rd_addr = '0;
        o_wr_addr = '0;
        n_i       = r_i;
        n_k       = r_k;
        n_j       = r_j;
        n_s       = r_s;
        n_c       = r_c;
        case (r_state)
            r2ntt_pkg::ST_IDLE: begin
                cmd.latch = i_start;
            end
            r2ntt_pkg::ST_DISPATCH: begin
                case (i_stat.kind)
                    r2ntt_pkg::REQ_LOAD: begin
                        if (i_stat.idx_err) begin
                            cmd.resp = r2ntt_pkg::RESP_ERR;
                        end else begin
                            cmd.red_go = 1'b1;
                            cmd.rsel   = r2ntt_pkg::RS_COEF;
                        end
                    end
                    r2ntt_pkg::REQ_READ: begin
                        if (i_stat.idx_err) begin
                            cmd.resp = r2ntt_pkg::RESP_ERR;
                        end else begin
                            cmd.rd_en = 1'b1;
                            o_rd_addr = idx_addr;
                        end
                    end
                    r2ntt_pkg::REQ_XFORM: begin
                        cmd.red_go = 1'b1;
                        cmd.rsel   = r2ntt_pkg::RS_ROOT;
                    end
                    default: cmd.resp = r2ntt_pkg::RESP_ZERO;
                endcase
            end
            r2ntt_pkg::ST_LD_WAIT: begin
                if (i_stat.red_done) begin
                    cmd.wr_en = 1'b1;
                    cmd.wsel  = r2ntt_pkg::WS_RED;
                    o_wr_addr = idx_addr;
                    cmd.resp  = r2ntt_pkg::RESP_ZERO;
                end
            end
            r2ntt_pkg::ST_RD_OUT: cmd.resp = r2ntt_pkg::RESP_READ;
            r2ntt_pkg::ST_ROOT_WAIT: begin
                if (i_stat.red_done) begin
                    cmd.ld_w0 = 1'b1;
                    n_i       = '0;
                end
            end
            r2ntt_pkg::ST_RED_RD: begin
                cmd.rd_en = 1'b1;
                o_rd_addr = r_i[AW-1:0];
            end
            r2ntt_pkg::ST_RED_GO: begin
                cmd.red_go = 1'b1;
                cmd.rsel   = r2ntt_pkg::RS_RDATA;
            end
            r2ntt_pkg::ST_RED_WAIT: begin
                if (i_stat.red_done) begin
                    cmd.wr_en = 1'b1;
                    cmd.wsel  = r2ntt_pkg::WS_RED;
                    o_wr_addr = r_i[AW-1:0];
                    n_i       = last_i ? '0 : r_i + CW'(1);
                end
            end
            r2ntt_pkg::ST_BR_CHK: begin
                if (!swap_need) begin
                    n_i = r_i + CW'(1);
                    n_s = SW'(1);
                end
            end
            r2ntt_pkg::ST_BR_RD1: begin
                cmd.rd_en = 1'b1;
                o_rd_addr = r_i[AW-1:0];
            end
            r2ntt_pkg::ST_BR_RD2: begin
                cmd.rd_en = 1'b1;
                o_rd_addr = rev;
                cmd.ld_x  = 1'b1;
            end
            r2ntt_pkg::ST_BR_CAP: cmd.ld_y = 1'b1;
            r2ntt_pkg::ST_BR_WR1: begin
                cmd.wr_en = 1'b1;
                cmd.wsel  = r2ntt_pkg::WS_Y;
                o_wr_addr = r_i[AW-1:0];
            end
            r2ntt_pkg::ST_BR_WR2: begin
                cmd.wr_en = 1'b1;
                cmd.wsel  = r2ntt_pkg::WS_X;
                o_wr_addr = rev;
                n_i       = r_i + CW'(1);
                n_s       = SW'(1);
            end
            r2ntt_pkg::ST_INIT: begin
                if (!stage_over) begin
                    cmd.ld_a_w0 = 1'b1;
                    n_c         = LW'(SW'(i_lg) - r_s);
                end
            end
            r2ntt_pkg::ST_SQ: begin
                if (r_c != '0) begin
                    cmd.mul_go = 1'b1;
                    cmd.msel   = r2ntt_pkg::MS_AA;
                end
            end
            r2ntt_pkg::ST_SQ_WAIT: begin
                if (i_stat.mul_done) begin
                    cmd.ld_a_mul = 1'b1;
                    n_c          = r_c - LW'(1);
                end
            end
            r2ntt_pkg::ST_TW_INIT: begin
                if (i_nega) begin
                    cmd.mul_go = 1'b1;
                    cmd.msel   = r2ntt_pkg::MS_AA;
                end else begin
                    cmd.wld = r2ntt_pkg::WL_ONE;
                    cmd.sld = r2ntt_pkg::SL_A;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            r2ntt_pkg::ST_TW_SQW: begin
                if (i_stat.mul_done) begin
                    cmd.wld = r2ntt_pkg::WL_A;
                    cmd.sld = r2ntt_pkg::SL_MUL;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            r2ntt_pkg::ST_BF_RD1: begin
                cmd.rd_en = 1'b1;
                o_rd_addr = k_h[AW-1:0];
            end
            r2ntt_pkg::ST_BF_RD2: begin
                cmd.rd_en = 1'b1;
                o_rd_addr = r_k[AW-1:0];
                cmd.ld_y  = 1'b1;
            end
            r2ntt_pkg::ST_BF_MUL: begin
                cmd.ld_x   = 1'b1;
                cmd.mul_go = 1'b1;
                cmd.msel   = r2ntt_pkg::MS_WY;
            end
            r2ntt_pkg::ST_BF_WR1: begin
                cmd.wr_en = 1'b1;
                cmd.wsel  = r2ntt_pkg::WS_SUM;
                o_wr_addr = r_k[AW-1:0];
            end
            r2ntt_pkg::ST_BF_WR2: begin
                cmd.wr_en = 1'b1;
                cmd.wsel  = r2ntt_pkg::WS_DIF;
                o_wr_addr = k_h[AW-1:0];
                if (k_next < len) begin
                    n_k = k_next;
                end
            end
            r2ntt_pkg::ST_TW_STEP: begin
                if (last_j) begin
                    n_s = r_s + SW'(1);
                end else begin
                    cmd.mul_go = 1'b1;
                    cmd.msel   = r2ntt_pkg::MS_WS;
                end
            end
            r2ntt_pkg::ST_TW_SW: begin
                if (i_stat.mul_done) begin
                    cmd.wld = r2ntt_pkg::WL_MUL;
                    n_j     = r_j + CW'(1);
                    n_k     = r_j + CW'(1);
                end
            end
            r2ntt_pkg::ST_DONE: cmd.resp = r2ntt_pkg::RESP_DONE;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= r2ntt_pkg::ST_IDLE;
            r_i     <= '0;
            r_k     <= '0;
            r_j     <= '0;
            r_s     <= '0;
            r_c     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_k     <= n_k;
            r_j     <= n_j;
            r_s     <= n_s;
            r_c     <= n_c;
        end
    end

    assign o_busy = (r_state != r2ntt_pkg::ST_IDLE);
    assign o_cmd  = cmd;

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == r2ntt_pkg::ST_IDLE && i_start) |=> (r_state == r2ntt_pkg::ST_DISPATCH))
        else $error("accepted request not dispatched");

    a_resp_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.resp != r2ntt_pkg::RESP_NONE) |=> (r_state == r2ntt_pkg::ST_IDLE))
        else $error("result issued without returning to idle");

    a_one_port_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.rd_en && cmd.wr_en))
        else $error("memory read and write in the same cycle");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.mul_go && cmd.red_go))
        else $error("both arithmetic units started together");

endmodule

`default_nettype wire

>>> rtl/core/radix2_ntt_engine.sv
// radix2_ntt_engine: top level, configuration registers, controller and datapath
// depends on r2ntt_pkg, r2ntt_ctrl, r2ntt_dp
//
// usage
//  - request channel: a request is taken on a rising edge with start high and busy
//    low; req_type 0 loads a coefficient, 1 runs the transform, 2 reads an entry
//  - result channel: every request gives one result, shown on o_res for exactly
//    one cycle with o_valid high; the receiver cannot hold it off
//  - configuration channel: i_cfg_valid with i_cfg_index / i_cfg_data, always ready;
//    registers modulus, root, log_size and negacyclic are to be written by the user
//    only while idle; the block itself does not enforce this
//  - results: a read answers after its memory read, a bad index or unknown request
//    from dispatch, a load after the remainder unit (one remainder bit per cycle)
//  - transform: a reduction pass through the remainder unit, a bit-reversal pass,
//    and per butterfly reads, a multiply (one multiplier bit per cycle) and writes;
//    twiddle steps and stage powers go through the same serial multiplier
//  - one request is in flight at a time; a new one can be taken in the cycle its
//    predecessor's result is shown
//  - reset clears the control state and sets modulus 2, root 1, log_size 0,
//    cyclic mode; memory contents are undefined until written
`default_nettype none

module radix2_ntt_engine #(
    parameter int MAX_SIZE  = 1024,
    parameter int WORD_BITS = 60
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  r2ntt_pkg::t_in                     i_req,
    output logic                               o_valid,
    output r2ntt_pkg::t_out                    o_res,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [r2ntt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [r2ntt_pkg::RES_W-1:0]         i_cfg_data
);

    localparam int AW     = $clog2(MAX_SIZE);
    localparam int MAX_LG = $clog2(MAX_SIZE + 1) - 1;
    localparam int LW     = $clog2(AW + 1);
    localparam int W      = r2ntt_pkg::RES_W;

    // configuration registers
    logic [W-1:0]                  r_modulus;
    logic [W-1:0]                  r_root;
    logic [r2ntt_pkg::LOG_W-1:0]   r_log_size;
    logic                          r_nega;

    // effective modulus and length
    logic [W-1:0]  p_eff;
    logic [LW-1:0] lg_eff;

    r2ntt_pkg::t_cmd  cmd;
    r2ntt_pkg::t_stat stat;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= W'(2);
            r_root     <= W'(1);
            r_log_size <= '0;
            r_nega     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (r2ntt_pkg::t_cfg_idx'(i_cfg_index))
                r2ntt_pkg::CFG_MODULUS:    r_modulus  <= i_cfg_data;
                r2ntt_pkg::CFG_ROOT:       r_root     <= i_cfg_data;
                r2ntt_pkg::CFG_LOG_SIZE:   r_log_size <= i_cfg_data[r2ntt_pkg::LOG_W-1:0];
                r2ntt_pkg::CFG_NEGACYCLIC: r_nega     <= i_cfg_data[0];
                default:                   r_nega     <= r_nega;
            endcase
        end
    end

    // a modulus below two acts as two; a length beyond the store is clamped
    // to the largest power of two that fits
    assign p_eff  = (r_modulus < W'(2)) ? W'(2) : r_modulus;
    assign lg_eff = (32'(r_log_size) > MAX_LG) ? LW'(MAX_LG) : LW'(r_log_size);

    r2ntt_ctrl #(
        .AW (AW),
        .LW (LW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_lg      (lg_eff),
        .i_nega    (r_nega),
        .i_stat    (stat),
        .o_busy    (busy),
        .o_cmd     (cmd),
        .o_rd_addr (rd_addr),
        .o_wr_addr (wr_addr)
    );

    r2ntt_dp #(
        .MAX_SIZE  (MAX_SIZE),
        .WORD_BITS (WORD_BITS),
        .AW        (AW),
        .LW        (LW)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_p       (p_eff),
        .i_root    (r_root),
        .i_lg      (lg_eff),
        .i_cmd     (cmd),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .o_stat    (stat),
        .o_valid   (o_valid),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

>>> verif/radix2_ntt_checker.sv
// ntt_result_checker: shadows the ntt engine's registers and coefficient store,
// works out each result from the requests it sees and compares them; needs r2ntt_pkg
`default_nettype none

module ntt_result_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    input  wire                            busy,
    input  r2ntt_pkg::t_in                 i_req,
    input  wire                            i_valid,
    input  r2ntt_pkg::t_out                i_res,
    input  wire                            i_cfg_valid,
    input  wire                            i_cfg_ready,
    input  wire [r2ntt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [r2ntt_pkg::RES_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam int RES_W       = r2ntt_pkg::RES_W;
    localparam int LOG_W       = r2ntt_pkg::LOG_W;
    localparam int STORE_DEPTH = 1024;
    localparam int MAX_LOG     = 10;

    logic [RES_W-1:0] sh_modulus;
    logic [RES_W-1:0] sh_root;
    logic [LOG_W-1:0] sh_log_size;
    logic             sh_negacyclic;
    logic [RES_W-1:0] coeff_mirror [STORE_DEPTH];
    r2ntt_pkg::t_out  awaited_results [$];
    int               fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = awaited_results.size();

    function automatic logic [RES_W-1:0] field_prime();
        return (sh_modulus < 2) ? RES_W'(2) : sh_modulus;
    endfunction

    function automatic int field_log();
        return (int'(sh_log_size) > MAX_LOG) ? MAX_LOG : int'(sh_log_size);
    endfunction

    function automatic logic [RES_W-1:0] mod_mul(input logic [RES_W-1:0] a,
                                                 input logic [RES_W-1:0] b,
                                                 input logic [RES_W-1:0] p);
        logic [2*RES_W-1:0] prod;
        prod = {{RES_W{1'b0}}, a} * {{RES_W{1'b0}}, b};
        return RES_W'(prod % {{RES_W{1'b0}}, p});
    endfunction

    function automatic logic [RES_W-1:0] mod_pow(input logic [RES_W-1:0] base,
                                                 input int unsigned e,
                                                 input logic [RES_W-1:0] p);
        logic [RES_W-1:0] acc;
        acc = 1 % p;
        while (e != 0) begin
            if (e[0]) begin
                acc = mod_mul(acc, base, p);
            end
            base = mod_mul(base, base, p);
            e = e >> 1;
        end
        return acc;
    endfunction

    // in-place transform on the mirrored store
    task automatic mirror_transform();
        logic [RES_W-1:0] p, w0, a, w, stp, t, u, tmp;
        int lg, n, r, h;
        p  = field_prime();
        lg = field_log();
        n  = 1 << lg;
        w0 = sh_root % p;
        for (int i = 0; i < n; i++) begin
            coeff_mirror[i] = coeff_mirror[i] % p;
        end
        for (int i = 0; i < n; i++) begin
            r = 0;
            for (int b = 0; b < lg; b++) begin
                r |= ((i >> b) & 1) << (lg - 1 - b);
            end
            if (r > i) begin
                tmp = coeff_mirror[i];
                coeff_mirror[i] = coeff_mirror[r];
                coeff_mirror[r] = tmp;
            end
        end
        for (int m = 2; m <= n; m = m << 1) begin
            a = mod_pow(w0, n / m, p);
            h = m >> 1;
            if (sh_negacyclic) begin
                w   = a;
                stp = mod_mul(a, a, p);
            end else begin
                w   = 1 % p;
                stp = a;
            end
            for (int j = 0; j < h; j++) begin
                for (int k = j; k < n; k += m) begin
                    t = mod_mul(w, coeff_mirror[k + h], p);
                    u = coeff_mirror[k];
                    coeff_mirror[k]     = r2ntt_pkg::add_mod(u, t, p);
                    coeff_mirror[k + h] = r2ntt_pkg::sub_mod(u, t, p);
                end
                w = mod_mul(w, stp, p);
            end
        end
    endtask

    task automatic predict_result(input r2ntt_pkg::t_in rq);
        r2ntt_pkg::t_out exp_res;
        int              n;
        exp_res = '0;
        n = 1 << field_log();
        case (r2ntt_pkg::t_req_kind'(rq.req_type))
            r2ntt_pkg::REQ_LOAD, r2ntt_pkg::REQ_READ: begin
                if (int'(rq.index) >= n) begin
                    exp_res.index_error = 1'b1;
                end else if (r2ntt_pkg::t_req_kind'(rq.req_type) == r2ntt_pkg::REQ_LOAD) begin
                    coeff_mirror[rq.index] = rq.coeff_value % field_prime();
                end else begin
                    exp_res.read_value = coeff_mirror[rq.index];
                end
            end
            r2ntt_pkg::REQ_XFORM: begin
                mirror_transform();
                exp_res.transform_done = 1'b1;
            end
            default: ;
        endcase
        awaited_results.push_back(exp_res);
    endtask

    task automatic report(input string what, input r2ntt_pkg::t_out exp_res,
                          input r2ntt_pkg::t_out got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch (%s): expected value %h err %b done %b,",
                     what, exp_res.read_value, exp_res.index_error,
                     exp_res.transform_done);
            $display("    got value %h err %b done %b",
                     got.read_value, got.index_error, got.transform_done);
        end
    endtask

    always @(posedge i_clk) begin
        r2ntt_pkg::t_out exp_res;
        if (!i_rst_n) begin
            sh_modulus    <= RES_W'(2);
            sh_root       <= RES_W'(1);
            sh_log_size   <= '0;
            sh_negacyclic <= 1'b0;
            fail_count    = 0;
            awaited_results.delete();
        end else begin
            // results first: one shown alongside a new request belongs to the older one
            if (i_valid) begin
                if (awaited_results.size() == 0) begin
                    report("unexpected result", '0, i_res);
                end else begin
                    exp_res = awaited_results.pop_front();
                    if (i_res.read_value != exp_res.read_value ||
                        i_res.index_error != exp_res.index_error ||
                        i_res.transform_done != exp_res.transform_done) begin
                        report("result fields", exp_res, i_res);
                    end
                end
            end
            if (start && !busy) begin
                predict_result(i_req);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (r2ntt_pkg::t_cfg_idx'(i_cfg_index))
                    r2ntt_pkg::CFG_MODULUS:    sh_modulus    <= i_cfg_data;
                    r2ntt_pkg::CFG_ROOT:       sh_root       <= i_cfg_data;
                    r2ntt_pkg::CFG_LOG_SIZE:   sh_log_size   <= i_cfg_data[LOG_W-1:0];
                    r2ntt_pkg::CFG_NEGACYCLIC: sh_negacyclic <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> verif/radix2_ntt_engine_test.sv
// radix2_ntt_engine_test: request and configuration stimulus for the ntt engine
// depends on r2ntt_pkg, radix2_ntt_engine and ntt_result_checker
`default_nettype none

module radix2_ntt_engine_test;

    localparam int               RES_W     = r2ntt_pkg::RES_W;
    localparam int               IDX_W     = r2ntt_pkg::IDX_W;
    localparam int               CFG_IDX_W = r2ntt_pkg::CFG_IDX_W;
    localparam int               IN_W      = $bits(r2ntt_pkg::t_in);
    localparam logic [RES_W-1:0] RES_MAX   = {RES_W{1'b1}};
    localparam int               PHASES    = 16;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    r2ntt_pkg::t_in       i_req = '0;
    logic                 o_valid;
    r2ntt_pkg::t_out      o_res;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [RES_W-1:0]     i_cfg_data = '0;
    int                   fail_count;
    int                   pending;

    // which store entries hold a value, so nothing unwritten is ever read
    bit                   loaded [1024];
    int                   cur_size;
    bit                   allow_gaps;

    always #1 i_clk = ~i_clk;

    radix2_ntt_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    ntt_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .i_valid      (o_valid),
        .i_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic [RES_W-1:0] rand_res();
        return RES_W'({$urandom(), $urandom()});
    endfunction

    // one request; start stays high into the next request if there is no gap
    task automatic send_request(input r2ntt_pkg::t_req_kind kind, input int idx,
                                input logic [RES_W-1:0] val);
        r2ntt_pkg::t_in rq;
        rq.req_type    = kind;
        rq.index       = IDX_W'(idx);
        rq.coeff_value = val;
        while (allow_gaps && $urandom_range(99) < 11) begin
            start <= 1'b0;
            i_req <= IN_W'({$urandom(), $urandom(), $urandom()});
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (busy);
        if (kind == r2ntt_pkg::REQ_LOAD && idx < cur_size) begin
            loaded[idx] = 1'b1;
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        // loads end on their result, a short pause is enough
        repeat (4) @(posedge i_clk);
    endtask

    // valid stays high into the next write; the caller drops it after the last
    task automatic write_reg(input r2ntt_pkg::t_cfg_idx idx, input logic [RES_W-1:0] data);
        while (allow_gaps && $urandom_range(99) < 11) begin
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // full register set, then fill any entries of the new length not yet loaded
    task automatic set_mode(input logic [RES_W-1:0] p, input logic [RES_W-1:0] w,
                            input int lg, input bit neg);
        int eff_lg;
        drain();
        write_reg(r2ntt_pkg::CFG_LOG_SIZE, RES_W'(lg));
        write_reg(r2ntt_pkg::CFG_ROOT, w);
        write_reg(r2ntt_pkg::CFG_NEGACYCLIC, RES_W'(neg));
        write_reg(r2ntt_pkg::CFG_MODULUS, p);
        i_cfg_valid <= 1'b0;
        eff_lg   = (lg > 10) ? 10 : lg;
        cur_size = 1 << eff_lg;
        for (int i = 0; i < cur_size; i++) begin
            if (!loaded[i]) begin
                send_request(r2ntt_pkg::REQ_LOAD, i, rand_res());
            end
        end
    endtask

    task automatic random_request();
        int                  pick, idx;
        r2ntt_pkg::t_req_kind kind;
        pick = $urandom_range(99);
        if (pick < 45) begin
            kind = r2ntt_pkg::REQ_LOAD;
        end else if (pick < 80) begin
            kind = r2ntt_pkg::REQ_READ;
        end else if (pick < 90) begin
            kind = r2ntt_pkg::REQ_XFORM;
        end else begin
            kind = r2ntt_pkg::REQ_NONE;
        end
        // mostly in range, sometimes any index so the bad-index path is hit
        idx = ($urandom_range(99) < 85) ? $urandom_range(cur_size - 1) : $urandom_range(1023);
        if (kind == r2ntt_pkg::REQ_READ && idx < cur_size && !loaded[idx]) begin
            kind = r2ntt_pkg::REQ_LOAD;
        end
        send_request(kind, idx, rand_res());
    endtask

    initial begin
        #40000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [RES_W-1:0] p, w;
        int               lg;
        allow_gaps = 1'b1;
        cur_size   = 1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // length one at reset settings: bad indexes, unknown request, bare reduction
        send_request(r2ntt_pkg::REQ_LOAD, 0, RES_MAX);
        send_request(r2ntt_pkg::REQ_READ, 0, '0);
        send_request(r2ntt_pkg::REQ_LOAD, 1, RES_W'(5));
        send_request(r2ntt_pkg::REQ_READ, 1023, '0);
        send_request(r2ntt_pkg::REQ_NONE, 1023, RES_MAX);
        send_request(r2ntt_pkg::REQ_XFORM, 0, '0);
        send_request(r2ntt_pkg::REQ_READ, 0, '0);

        // small prime, length 8, extreme coefficient values
        set_mode(RES_W'(998244353), RES_W'(372528824), 3, 1'b0);
        send_request(r2ntt_pkg::REQ_LOAD, 0, '0);
        send_request(r2ntt_pkg::REQ_LOAD, 7, RES_MAX);
        send_request(r2ntt_pkg::REQ_LOAD, 3, RES_W'(998244352));
        send_request(r2ntt_pkg::REQ_XFORM, 0, '0);
        for (int i = 0; i < 8; i++) begin
            send_request(r2ntt_pkg::REQ_READ, i, '0);
        end
        send_request(r2ntt_pkg::REQ_LOAD, 8, RES_W'(1));

        // random phases through modulus, root, length and mode settings
        for (int ph = 0; ph < PHASES; ph++) begin
            allow_gaps = !(ph >= 3 && ph <= 5);
            case (ph % 6)
                0: p = RES_MAX;
                1: p = '0;
                2: p = RES_W'(1);
                3: p = RES_W'(2);
                4: p = RES_W'(998244353);
                default: p = rand_res();
            endcase
            case ($urandom_range(3))
                0: w = '0;
                1: w = RES_MAX;
                default: w = rand_res();
            endcase
            lg = (ph == 7) ? 15 : $urandom_range(4);
            set_mode(p, w, lg, 1'($urandom_range(1)));
            if (lg > 10) begin
                send_request(r2ntt_pkg::REQ_XFORM, 0, '0);
                send_request(r2ntt_pkg::REQ_READ, 1023, '0);
                send_request(r2ntt_pkg::REQ_READ, 0, '0);
            end else begin
                repeat (30) random_request();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/core/r2ntt_pkg.sv
rtl/core/r2ntt_modred.sv
rtl/core/r2ntt_mulmod.sv
rtl/core/r2ntt_dp.sv
rtl/core/r2ntt_ctrl.sv
rtl/core/radix2_ntt_engine.sv
verif/radix2_ntt_checker.sv
verif/radix2_ntt_engine_test.sv
